// ----- hdl/psg_pkg.sv -----
// ---------------------------------------------------------------------------
// psg_pkg: shared types and constants of the PSG tone generator
// Beat layouts, register map codes and the control bundles that pass
// between the top level, the serial divider and the serial phase unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package psg_pkg;

  localparam int unsigned NumTones   = 3;
  localparam int unsigned PhaseWidth = 29;
  localparam int unsigned RateWidth  = 32;
  localparam int unsigned PeriodWidth = 10;
  localparam int unsigned CountWidth = $clog2(RateWidth);
  localparam int unsigned AddrWidth  = 3;

  localparam logic [RateWidth-1:0] RateReset = 32'h512b_3400;

  // Register index codes on the configuration port
  localparam logic RegRateConstant = 1'b0;

  // Input opcodes
  localparam logic OpWrite = 1'b0;
  localparam logic OpTick  = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] write_byte;
  } psg_in_t;

  typedef struct packed {
    logic [7:0] tone0_level;
    logic [7:0] tone1_level;
    logic [7:0] tone2_level;
  } psg_out_t;

  // Divider result toward the top level
  typedef struct packed {
    logic                 done;
    logic [RateWidth-1:0] quotient;
  } psg_div_res_t;

  // Phase increment load toward the phase unit
  typedef struct packed {
    logic                  en;
    logic [1:0]            ch;
    logic [PhaseWidth-1:0] value;
  } psg_step_wr_t;

endpackage

// ----- hdl/psg_divider.sv -----
// ---------------------------------------------------------------------------
// psg_divider: bit-serial restoring divider
// Divides the 32-bit rate constant by a nonzero 10-bit period, one
// quotient bit per cycle, most significant bit first.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module psg_divider (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [psg_pkg::RateWidth-1:0]   dividend,
  input  logic [psg_pkg::PeriodWidth-1:0] divisor,
  output psg_pkg::psg_div_res_t        res
);
  import psg_pkg::*;

  logic                   busy_r;
  logic                   done_r;
  logic [CountWidth-1:0]  cnt_r;
  logic [RateWidth-1:0]   dvd_r;
  logic [RateWidth-1:0]   quo_r;
  logic [PeriodWidth-1:0] dvsr_r;
  logic [PeriodWidth-1:0] rem_r;

  logic [PeriodWidth:0]   trial;
  logic                   fits;
  logic [PeriodWidth:0]   diff;
  logic [PeriodWidth-1:0] rem_nxt;

  // Shift the next dividend bit into the partial remainder and try a subtract
  always_comb begin
    trial   = {rem_r, dvd_r[RateWidth-1]};
    fits    = (trial >= {1'b0, dvsr_r});
    diff    = trial - {1'b0, dvsr_r};
    rem_nxt = fits ? diff[PeriodWidth-1:0] : trial[PeriodWidth-1:0];
  end

  // Control: count 32 steps, pulse done at the end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CountWidth'(RateWidth - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift dividend out and quotient in
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r  <= dividend;
      dvsr_r <= divisor;
      rem_r  <= '0;
      quo_r  <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[RateWidth-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[RateWidth-2:0], fits};
    end
  end

  assign res.done     = done_r;
  assign res.quotient = quo_r;

endmodule

// ----- hdl/psg_phase.sv -----
// ---------------------------------------------------------------------------
// psg_phase: bit-serial phase accumulators
// Holds three 29-bit accumulators and their increments as rotating shift
// registers; one tick adds all three, one bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module psg_phase (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  psg_pkg::psg_step_wr_t      step_wr,
  output logic                       done,
  output logic [psg_pkg::NumTones-1:0] phase_top
);
  import psg_pkg::*;

  logic                  busy_r;
  logic                  done_r;
  logic [CountWidth-1:0] cnt_r;
  logic [PhaseWidth-1:0] acc_r  [NumTones];
  logic [PhaseWidth-1:0] stp_r  [NumTones];
  logic [NumTones-1:0]   carry_r;

  // Control: run 29 bit steps per tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CountWidth'(PhaseWidth - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Serial add per channel; rotate both words so they realign at the end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r <= '0;
      for (int i = 0; i < NumTones; i++) begin
        acc_r[i] <= '0;
        stp_r[i] <= '0;
      end
    end else begin
      if (start) begin
        carry_r <= '0;
      end else if (busy_r) begin
        for (int i = 0; i < NumTones; i++) begin
          acc_r[i]   <= {acc_r[i][0] ^ stp_r[i][0] ^ carry_r[i], acc_r[i][PhaseWidth-1:1]};
          stp_r[i]   <= {stp_r[i][0], stp_r[i][PhaseWidth-1:1]};
          carry_r[i] <= (acc_r[i][0] & stp_r[i][0]) | (carry_r[i] & (acc_r[i][0] ^ stp_r[i][0]));
        end
      end
      // Load a new increment; never overlaps a running tick
      if (step_wr.en) begin
        for (int i = 0; i < NumTones; i++) begin
          if (step_wr.ch == 2'(i)) begin
            stp_r[i] <= step_wr.value;
          end
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NumTones; i++) begin
      phase_top[i] = acc_r[i][PhaseWidth-1];
    end
  end

  assign done = done_r;

endmodule

// ----- hdl/psg_tone_generator.sv -----
// ---------------------------------------------------------------------------
// psg_tone_generator: tone section of a programmable sound generator
// Decodes register write bytes, computes phase increments and produces
// three tone levels per sample tick.
// ---------------------------------------------------------------------------
// Usage:
//   Input beats (in_valid/in_stall/in_data) carry either a register write
//   byte (opcode 0) or a sample tick (opcode 1). Each tick yields one output
//   beat (out_valid/out_stall/out_data) with three channel levels; writes
//   yield none.
//   Flow: a volume write, a channel 3 frequency write or a tone frequency
//   write with a zero period leaves the block idle; any other tone
//   frequency write runs the 32-step serial divider that computes the
//   phase increment. A tick runs the 29-bit serial phase adder. One item
//   is in work at a time; in_stall is high while it runs.
//   The output register holds a finished beat while the next item is taken;
//   a tick that finishes while out_stall still holds the previous beat waits
//   until that beat leaves.
//   Reset (rst_n low, synchronous) holds in_stall, clears volumes, periods,
//   phases and increments and loads rate_constant with 0x512b3400. It sits
//   at byte address 0 of the APB port. The user must see that it is written
//   only while idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module psg_tone_generator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  psg_pkg::psg_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output psg_pkg::psg_out_t             out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [psg_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import psg_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_TICK,
    ST_HOLD
  } state_t;

  state_t                 state_r;
  logic [RateWidth-1:0]   rate_r;
  logic [1:0]             latched_r;
  logic [7:0]             vol_r  [NumTones];
  logic [3:0]             plow_r [4];
  logic [5:0]             phigh_r [4];
  logic [1:0]             div_ch_r;
  logic                   out_valid_r;
  psg_out_t               out_data_r;

  logic                   accept;
  logic                   out_free;
  logic [1:0]             byte_ch;
  logic                   is_freq;
  logic [1:0]             freq_ch;
  logic [3:0]             new_low;
  logic [5:0]             new_high;
  logic [PeriodWidth-1:0] new_period;
  logic                   div_start;
  logic                   tick_start;
  psg_div_res_t           div_res;
  psg_step_wr_t           step_wr;
  logic                   phase_done;
  logic [NumTones-1:0]    phase_top;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegRateConstant) ? rate_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= RateReset;
    end else if (psel && penable && pwrite && (paddr[2] == RegRateConstant)) begin
      rate_r <= pwdata;
    end
  end

  // Write byte decode; period formed from the halves as they will stand
  always_comb begin
    accept   = in_valid && !in_stall;
    out_free = !out_valid_r || !out_stall;
    byte_ch  = in_data.write_byte[6:5];
    is_freq  = !in_data.write_byte[7] || !in_data.write_byte[4];
    freq_ch  = in_data.write_byte[7] ? byte_ch : latched_r;
    new_low  = in_data.write_byte[7] ? in_data.write_byte[3:0] : plow_r[freq_ch];
    new_high = in_data.write_byte[7] ? phigh_r[freq_ch] : in_data.write_byte[5:0];
    new_period = {new_high, new_low};
    div_start  = accept && (in_data.opcode == OpWrite) && is_freq
                 && (freq_ch != 2'd3) && (new_period != '0);
    tick_start = accept && (in_data.opcode == OpTick);
  end

  // Increment load: zero at once for a zero period, else the quotient
  always_comb begin
    step_wr.en    = 1'b0;
    step_wr.ch    = div_ch_r;
    step_wr.value = div_res.quotient[PhaseWidth-1:0];
    if (div_res.done) begin
      step_wr.en = 1'b1;
    end else if (accept && (in_data.opcode == OpWrite) && is_freq
                 && (freq_ch != 2'd3) && (new_period == '0)) begin
      step_wr.en    = 1'b1;
      step_wr.ch    = freq_ch;
      step_wr.value = '0;
    end
  end

  psg_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rate_r),
    .divisor  (new_period),
    .res      (div_res)
  );

  psg_phase u_phase (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (tick_start),
    .step_wr   (step_wr),
    .done      (phase_done),
    .phase_top (phase_top)
  );

  // Sequencer, register file and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      latched_r   <= '0;
      div_ch_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NumTones; i++) begin
        vol_r[i] <= '0;
      end
      for (int i = 0; i < 4; i++) begin
        plow_r[i]  <= '0;
        phigh_r[i] <= '0;
      end
    end else begin
      // Drop the output beat once taken
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept && (in_data.opcode == OpWrite)) begin
            if (!is_freq) begin
              if (byte_ch != 2'd3) begin
                vol_r[byte_ch] <= {~in_data.write_byte[3:0], ~in_data.write_byte[3:0]};
              end
            end else begin
              plow_r[freq_ch]  <= new_low;
              phigh_r[freq_ch] <= new_high;
              if (in_data.write_byte[7]) begin
                latched_r <= byte_ch;
              end
              div_ch_r <= freq_ch;
              if (div_start) begin
                state_r <= ST_DIVIDE;
              end
            end
          end else if (tick_start) begin
            state_r <= ST_TICK;
          end
        end
        ST_DIVIDE: begin
          if (div_res.done) begin
            state_r <= ST_IDLE;
          end
        end
        ST_TICK: begin
          if (phase_done) begin
            state_r <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          // Wait for a free output slot, then load the beat
          if (out_free) begin
            out_valid_r            <= 1'b1;
            out_data_r.tone0_level <= phase_top[0] ? vol_r[0] : 8'd0;
            out_data_r.tone1_level <= phase_top[1] ? vol_r[1] : 8'd0;
            out_data_r.tone2_level <= phase_top[2] ? vol_r[2] : 8'd0;
            state_r                <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (state_r != ST_IDLE) || !rst_n;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
